@@ rtl/modular_arithmetic_unit_macros.svh @@
// Assertion macros shared by the modular arithmetic unit RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mau_pkg.sv @@
// Package for the modular arithmetic unit: widths, command codes, reset modulus
// and the request/response structs of the serial multiply-reduce unit. No dependencies.
package mau_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int RES_W        = 31;
    localparam int EXP_W        = (OPERAND_BITS > RES_W) ? OPERAND_BITS : RES_W;
    localparam int CNT_W        = $clog2(EXP_W);

    localparam logic [RES_W-1:0] MODULUS_RESET = RES_W'(1000000007);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;

    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] x;
        logic [EXP_W-1:0] y;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] prod;
    } mm_rsp_t;

endpackage

@@ rtl/modular_arithmetic_unit.sv @@
// Top level of the modular arithmetic unit: command sequencer, modulus register
// and result register. Depends on mau_pkg, mau_mulmod and the assertion macro header.
//
//  channel   handshake                       payload
//  --------  ------------------------------  ---------------------------
//  command   start & !busy                   cmd, operand_a, operand_b
//  result    done (one-cycle strobe)         residue
//  config    modulus_valid & modulus_ready   modulus
//
// Every multiply-reduce runs EXP_W (32) serial steps.
// Add and subtract run two operand reductions; multiply adds a third multiply-reduce.
// Power and divide add one squaring per exponent bit and one multiply per set bit.
// Modulus below two or an unused command: the zero result strobes in the cycle after start.
// Reset loads the modulus with 1000000007 and idles the sequencer; done cannot be stalled.
`include "modular_arithmetic_unit_macros.svh"

module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              cmd,
    input  logic [OPERAND_BITS-1:0] operand_a,
    input  logic [OPERAND_BITS-1:0] operand_b,
    input  logic                    modulus_valid,
    output logic                    modulus_ready,
    input  logic [RES_W-1:0]        modulus,
    output logic                    done,
    output logic [RES_W-1:0]        residue
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_POW_CHK,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_FINAL
    } state_t;

    state_t           state_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RES_W-1:0] modulus_reg;
    logic [RES_W-1:0] residue_reg;
    logic [2:0]       cmd_reg;
    logic [EXP_W-1:0] b_reg;
    logic [RES_W-1:0] ar_reg;
    logic [RES_W-1:0] base_reg;
    logic [RES_W-1:0] acc_reg;
    logic [EXP_W-1:0] exp_reg;
    mm_req_t          mm_req_reg;
    mm_rsp_t          mm_rsp;

    logic [RES_W:0]   add_sum;
    logic [RES_W:0]   add_diff;
    logic [RES_W-1:0] add_res;
    logic [RES_W-1:0] sub_res;
    logic             small_mod;

    mau_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mm_req_reg),
        .rsp     (mm_rsp)
    );

    always_comb
    begin
        add_sum   = {1'b0, ar_reg} + {1'b0, mm_rsp.prod};
        add_diff  = add_sum - {1'b0, modulus_reg};
        add_res   = (add_sum >= {1'b0, modulus_reg}) ? add_diff[RES_W-1:0] : add_sum[RES_W-1:0];
        sub_res   = ar_reg - mm_rsp.prod + ((ar_reg < mm_rsp.prod) ? modulus_reg : '0);
        small_mod = (modulus_reg < RES_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (modulus_valid)
        begin
            modulus_reg <= modulus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            mm_req_reg  <= '0;
            residue_reg <= '0;
            cmd_reg     <= CMD_ADD;
            b_reg       <= '0;
            ar_reg      <= '0;
            base_reg    <= '0;
            acc_reg     <= '0;
            exp_reg     <= '0;
        end
        else
        begin
            done_reg         <= 1'b0;
            mm_req_reg.start <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        b_reg   <= EXP_W'(operand_b);
                        if (small_mod || (cmd > CMD_POW))
                        begin
                            residue_reg <= '0;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            busy_reg         <= 1'b1;
                            mm_req_reg.start <= 1'b1;
                            mm_req_reg.x     <= RES_W'(1);
                            mm_req_reg.y     <= EXP_W'(operand_a);
                            state_reg        <= ST_RED_A;
                        end
                    end
                end
                ST_RED_A:
                begin
                    if (mm_rsp.done)
                    begin
                        ar_reg           <= mm_rsp.prod;
                        mm_req_reg.start <= 1'b1;
                        mm_req_reg.x     <= RES_W'(1);
                        mm_req_reg.y     <= b_reg;
                        state_reg        <= ST_RED_B;
                    end
                end
                ST_RED_B:
                begin
                    if (mm_rsp.done)
                    begin
                        case (cmd_reg)
                            CMD_ADD:
                            begin
                                residue_reg <= add_res;
                                done_reg    <= 1'b1;
                                busy_reg    <= 1'b0;
                                state_reg   <= ST_IDLE;
                            end
                            CMD_SUB:
                            begin
                                residue_reg <= sub_res;
                                done_reg    <= 1'b1;
                                busy_reg    <= 1'b0;
                                state_reg   <= ST_IDLE;
                            end
                            CMD_MUL:
                            begin
                                mm_req_reg.start <= 1'b1;
                                mm_req_reg.x     <= ar_reg;
                                mm_req_reg.y     <= EXP_W'(mm_rsp.prod);
                                state_reg        <= ST_FINAL;
                            end
                            CMD_DIV:
                            begin
                                if (mm_rsp.prod == '0)
                                begin
                                    residue_reg <= '0;
                                    done_reg    <= 1'b1;
                                    busy_reg    <= 1'b0;
                                    state_reg   <= ST_IDLE;
                                end
                                else
                                begin
                                    base_reg  <= mm_rsp.prod;
                                    exp_reg   <= EXP_W'(modulus_reg - RES_W'(2));
                                    acc_reg   <= RES_W'(1);
                                    state_reg <= ST_POW_CHK;
                                end
                            end
                            default:
                            begin
                                base_reg  <= ar_reg;
                                exp_reg   <= b_reg;
                                acc_reg   <= RES_W'(1);
                                state_reg <= ST_POW_CHK;
                            end
                        endcase
                    end
                end
                ST_POW_CHK:
                begin
                    if (exp_reg == '0)
                    begin
                        if (cmd_reg == CMD_DIV)
                        begin
                            mm_req_reg.start <= 1'b1;
                            mm_req_reg.x     <= ar_reg;
                            mm_req_reg.y     <= EXP_W'(acc_reg);
                            state_reg        <= ST_FINAL;
                        end
                        else
                        begin
                            residue_reg <= acc_reg;
                            done_reg    <= 1'b1;
                            busy_reg    <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    else if (exp_reg[0])
                    begin
                        mm_req_reg.start <= 1'b1;
                        mm_req_reg.x     <= acc_reg;
                        mm_req_reg.y     <= EXP_W'(base_reg);
                        state_reg        <= ST_POW_MUL;
                    end
                    else
                    begin
                        mm_req_reg.start <= 1'b1;
                        mm_req_reg.x     <= base_reg;
                        mm_req_reg.y     <= EXP_W'(base_reg);
                        state_reg        <= ST_POW_SQR;
                    end
                end
                ST_POW_MUL:
                begin
                    if (mm_rsp.done)
                    begin
                        acc_reg          <= mm_rsp.prod;
                        mm_req_reg.start <= 1'b1;
                        mm_req_reg.x     <= base_reg;
                        mm_req_reg.y     <= EXP_W'(base_reg);
                        state_reg        <= ST_POW_SQR;
                    end
                end
                ST_POW_SQR:
                begin
                    if (mm_rsp.done)
                    begin
                        base_reg  <= mm_rsp.prod;
                        exp_reg   <= {1'b0, exp_reg[EXP_W-1:1]};
                        state_reg <= ST_POW_CHK;
                    end
                end
                ST_FINAL:
                begin
                    if (mm_rsp.done)
                    begin
                        residue_reg <= mm_rsp.prod;
                        done_reg    <= 1'b1;
                        busy_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign residue       = residue_reg;
    assign modulus_ready = 1'b1;

    `MAU_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg && (state_reg == ST_IDLE),
        "result strobed while a transaction is in flight")
    `MAU_ASSERT_IMP(a_residue_range, clk, rst_n, done_reg && !small_mod,
        residue_reg < modulus_reg, "residue not reduced")
    `MAU_ASSERT_IMP(a_small_mod_zero, clk, rst_n, done_reg && small_mod,
        residue_reg == '0, "nonzero residue for modulus below two")
    `MAU_ASSERT_NXT(a_busy_on_accept, clk, rst_n, start && !busy_reg && !small_mod &&
        (cmd <= CMD_POW), busy_reg, "accepted transaction did not raise busy")

endmodule

@@ rtl/mau_mulmod.sv @@
// Bit-serial interleaved multiply-reduce: prod = x * y mod m, one bit of y per cycle.
// Requires x < m and m >= 2. Depends on mau_pkg and the assertion macro header.
`include "modular_arithmetic_unit_macros.svh"

module mau_mulmod
    import mau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RES_W-1:0] modulus,
    input  mm_req_t          req,
    output mm_rsp_t          rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] acc_next;
    logic [RES_W-1:0] x_reg;
    logic [EXP_W-1:0] y_reg;

    logic [RES_W+1:0] sum;
    logic [RES_W+2:0] diff1;
    logic [RES_W+2:0] diff2;

    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0} + {2'b00, (y_reg[EXP_W-1] ? x_reg : '0)};
        diff1 = {1'b0, sum} - {3'b000, modulus};
        diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
        if (!diff2[RES_W+2])
        begin
            acc_next = diff2[RES_W-1:0];
        end
        else if (!diff1[RES_W+2])
        begin
            acc_next = diff1[RES_W-1:0];
        end
        else
        begin
            acc_next = sum[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(EXP_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            x_reg   <= req.x;
            y_reg   <= req.y;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[EXP_W-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    `MAU_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg, "mulmod done while busy")
    `MAU_ASSERT_IMP(a_no_restart, clk, rst_n, busy_reg, !req.start, "mulmod restarted while busy")
    `MAU_ASSERT_IMP(a_acc_reduced, clk, rst_n, done_reg && (modulus > RES_W'(1)),
        acc_reg < modulus, "mulmod product not reduced")

endmodule

@@ dv/modular_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for modular_arithmetic_unit: directed corner cases, then random
// commands over several moduli, each residue checked against a behavioral predictor.
// Depends on mau_pkg and the modular_arithmetic_unit RTL.
module modular_arithmetic_unit_tb;
    import mau_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int REPORT_MAX  = 10;

    // command codes the unit leaves unused
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [2:0]              op;
        logic [OPERAND_BITS-1:0] a;
        logic [OPERAND_BITS-1:0] b;
        logic [RES_W-1:0]        m;
        logic [RES_W-1:0]        residue;
    } pending_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [2:0]              cmd;
    logic [OPERAND_BITS-1:0] operand_a;
    logic [OPERAND_BITS-1:0] operand_b;
    logic                    modulus_valid;
    logic                    modulus_ready;
    logic [RES_W-1:0]        modulus;
    logic                    done;
    logic [RES_W-1:0]        residue;

    pending_t         pending_residues[$];
    logic [RES_W-1:0] active_modulus;
    int               mismatches;
    int               items_sent;
    int               results_checked;
    int               moduli_written;
    int               cycle_count;

    modular_arithmetic_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .modulus_valid (modulus_valid),
        .modulus_ready (modulus_ready),
        .modulus       (modulus),
        .done          (done),
        .residue       (residue)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned ex,
                                                longint unsigned m);
        longint unsigned acc;
        acc  = 1 % m;
        base = base % m;
        while (ex != 0)
        begin
            if (ex[0])
                acc = (acc * base) % m;
            base = (base * base) % m;
            ex   = ex >> 1;
        end
        return acc;
    endfunction

    function automatic logic [RES_W-1:0] predict_residue(logic [2:0] op,
                                                         logic [OPERAND_BITS-1:0] a,
                                                         logic [OPERAND_BITS-1:0] b,
                                                         logic [RES_W-1:0] mod_value);
        longint unsigned m, ar, br, r;
        m = mod_value;
        r = 0;
        if (m >= 2)
        begin
            ar = a % m;
            br = b % m;
            case (op)
                CMD_ADD: r = (ar + br) % m;
                CMD_SUB: r = (ar + m - br) % m;
                CMD_MUL: r = (ar * br) % m;
                CMD_DIV: r = (br == 0) ? 0 : (ar * mod_pow(br, m - 2, m)) % m;
                CMD_POW: r = mod_pow(a, b, m);
                default: r = 0;
            endcase
        end
        return r[RES_W-1:0];
    endfunction

    // Drive one command and hold it until the unit takes it.
    task automatic send_command(logic [2:0] op, logic [OPERAND_BITS-1:0] a,
                                logic [OPERAND_BITS-1:0] b);
        pending_t p;
        @(negedge clk);
        start     <= 1'b1;
        cmd       <= op;
        operand_a <= a;
        operand_b <= b;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        p.op      = op;
        p.a       = a;
        p.b       = b;
        p.m       = active_modulus;
        p.residue = predict_residue(op, a, b, active_modulus);
        pending_residues.push_back(p);
        items_sent++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_residues.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(logic [RES_W-1:0] value);
        drain_results();
        @(negedge clk);
        modulus_valid <= 1'b1;
        modulus       <= value;
        forever
        begin
            @(posedge clk);
            if (modulus_ready)
                break;
        end
        active_modulus = value;
        moduli_written++;
        @(negedge clk);
        modulus_valid <= 1'b0;
    endtask

    function automatic logic [OPERAND_BITS-1:0] pick_operand(logic [RES_W-1:0] m);
        logic [OPERAND_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = OPERAND_BITS'($urandom_range(0, 16));
            3:       v = OPERAND_BITS'(m) * OPERAND_BITS'($urandom_range(0, 2));
            4:       v = OPERAND_BITS'(m) - 1;
            default: v = OPERAND_BITS'($urandom);
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        pending_t p;
        if (rst_n && done)
        begin
            if (pending_residues.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: residue %0d with no transaction outstanding", residue);
            end
            else
            begin
                p = pending_residues.pop_front();
                results_checked++;
                if (residue !== p.residue)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("ERROR: cmd %0d a %h b %h mod %0d: expected %0d got %0d",
                                 p.op, p.a, p.b, p.m, p.residue, residue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_residues.size());
            $display("modular_arithmetic_unit verification failed");
            $finish;
        end
    end

    task automatic test_reset_modulus();
        active_modulus = MODULUS_RESET;
        send_command(CMD_ADD, '1, '1);
        send_command(CMD_ADD, '0, '0);
        send_command(CMD_SUB, '0, 32'd1);
        send_command(CMD_SUB, '1, '0);
        send_command(CMD_MUL, '1, 32'hFFFF_FFFE);
        send_command(CMD_MUL, 32'(MODULUS_RESET) - 1, 32'(MODULUS_RESET) - 1);
        send_command(CMD_DIV, 32'd10, '0);
        // divisor equal to the modulus
        send_command(CMD_DIV, 32'd5, 32'(MODULUS_RESET));
        send_command(CMD_DIV, '1, 32'd3);
        send_command(CMD_POW, 32'd2, '0);
        send_command(CMD_POW, '0, '0);
        send_command(CMD_POW, '1, '1);
        send_command(CMD_RSVD5, '1, '1);
        send_command(CMD_RSVD6, 32'd7, 32'd9);
        send_command(CMD_RSVD7, 32'h1234_5678, 32'h9ABC_DEF0);
    endtask

    task automatic test_degenerate_modulus();
        write_modulus('0);
        send_command(CMD_ADD, 32'd3, 32'd4);
        send_command(CMD_POW, 32'd5, '0);
        write_modulus(RES_W'(1));
        send_command(CMD_POW, 32'd5, '0);
        send_command(CMD_DIV, 32'd3, 32'd1);
    endtask

    task automatic test_extreme_moduli();
        write_modulus('1);
        send_command(CMD_DIV, 32'd1, 32'h7FFF_FFFE);
        send_command(CMD_MUL, '1, '1);
        send_command(CMD_POW, 32'h7FFF_FFFF, 32'd3);
        write_modulus(RES_W'(2));
        send_command(CMD_SUB, '0, 32'd1);
        send_command(CMD_DIV, 32'd1, 32'd1);
    endtask

    task automatic test_composite_divide();
        // not a true quotient, but the same exponentiation is expected
        write_modulus(RES_W'(1000000));
        send_command(CMD_DIV, 32'd7, 32'd3);
    endtask

    task automatic test_random_traffic();
        logic [RES_W-1:0] moduli[8];
        int burst;
        int n;
        moduli[0] = MODULUS_RESET;
        moduli[1] = '1;
        moduli[2] = RES_W'(2);
        moduli[3] = RES_W'(7);
        moduli[4] = RES_W'(65521);
        moduli[5] = RES_W'($urandom_range(2, 32'h7FFF_FFFF));
        moduli[6] = RES_W'(1000000);
        moduli[7] = RES_W'($urandom_range(0, 1));
        for (int k = 0; k < 8; k++)
        begin
            write_modulus(moduli[k]);
            n = 0;
            while (n < 30)
            begin
                burst = $urandom_range(1, 8);
                for (int j = 0; j < burst && n < 30; j++)
                begin
                    send_command(3'($urandom_range(0, 7)), pick_operand(active_modulus),
                                 pick_operand(active_modulus));
                    n++;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(0, 20));
            end
            // hold off once until the pipeline is empty mid-phase
            if (k == 3)
            begin
                drain_results();
                send_command(CMD_POW, pick_operand(active_modulus), '1);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = CMD_ADD;
        operand_a     = '0;
        operand_b     = '0;
        modulus_valid = 1'b0;
        modulus       = '0;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        moduli_written  = 0;
        cycle_count     = 0;
        active_modulus  = MODULUS_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_reset_modulus();
        test_degenerate_modulus();
        test_extreme_moduli();
        test_composite_divide();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge clk);
        $display("covered %0d transactions (%0d residues checked) over %0d modulus writes,",
                 items_sent, results_checked, moduli_written);
        $display("all five commands, unused codes, zero, one, prime and composite moduli");
        if (mismatches == 0 && pending_residues.size() == 0)
            $display("modular_arithmetic_unit verification clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_residues.size());
            $display("modular_arithmetic_unit verification failed");
        end
        $finish;
    end

endmodule
